/* sv/tcpsa_pkg.sv */
// ----------------------------------------------------------------------------
// tcpsa_pkg
// Types, codes and helpers shared by the TCP segment accept and state core.
// ----------------------------------------------------------------------------
package tcpsa_pkg;

   localparam int unsigned SEQ_W    = 32;
   localparam int unsigned WIN_W    = 16;
   localparam int unsigned LEN_W    = 16;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [SEQ_W-1:0] HALF_RANGE        = 32'h8000_0000;
   localparam logic [WIN_W-1:0] SEND_WINDOW_RESET = 16'd10;

   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_SEND_SEQ = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEND_WINDOW      = 1'b1;

   typedef enum logic [2:0] {
      PH_LISTEN   = 3'd0,
      PH_SYNRCVD  = 3'd1,
      PH_ESTAB    = 3'd2,
      PH_FINWAIT1 = 3'd3,
      PH_FINWAIT2 = 3'd4,
      PH_CLOSING  = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      ACT_NONE   = 2'd0,
      ACT_SYNACK = 2'd1,
      ACT_FIN    = 2'd2,
      ACT_RST    = 2'd3
   } action_type;

   function automatic logic serial_lt(input logic [SEQ_W-1:0] a,
                                      input logic [SEQ_W-1:0] b);
      logic [SEQ_W-1:0] diff;
      diff = a - b;
      return diff > HALF_RANGE;
   endfunction

endpackage

/* sv/tcpsa_req_if.sv */
// ----------------------------------------------------------------------------
// tcpsa_req_if
// Segment item channel: valid/ready handshake with the received header fields.
// ----------------------------------------------------------------------------
interface tcpsa_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] seg_seq;
   logic [31:0] seg_ack;
   logic [15:0] seg_window;
   logic [15:0] payload_len;
   logic        flag_syn;
   logic        flag_ack;
   logic        flag_fin;

   modport source (output valid, seg_seq, seg_ack, seg_window, payload_len,
                   flag_syn, flag_ack, flag_fin, input ready);
   modport sink   (input valid, seg_seq, seg_ack, seg_window, payload_len,
                   flag_syn, flag_ack, flag_fin, output ready);
endinterface

/* sv/tcpsa_rsp_if.sv */
// ----------------------------------------------------------------------------
// tcpsa_rsp_if
// Result item channel: acceptance, requested action, state and reply fields.
// ----------------------------------------------------------------------------
interface tcpsa_rsp_if;
   import tcpsa_pkg::*;

   logic        valid;
   logic        ready;
   logic        accepted;
   action_type  action;
   phase_type   conn_state;
   logic [31:0] reply_seq;
   logic [31:0] reply_ack;
   logic [15:0] reply_window;

   modport source (output valid, accepted, action, conn_state, reply_seq,
                   reply_ack, reply_window, input ready);
   modport sink   (input valid, accepted, action, conn_state, reply_seq,
                   reply_ack, reply_window, output ready);
endinterface

/* sv/tcp_segment_accept_and_state_core.sv */
// ----------------------------------------------------------------------------
// tcp_segment_accept_and_state_core
// Receive side of one TCP connection: window acceptance and phase stepping.
// ----------------------------------------------------------------------------
// Registers: input register, then result register, with the connection state
// updated between the two. Throughput: one item per cycle while the result
// channel is not stalled; a stalled result holds the input register.
// Reset: synchronous, active high; phase listen, receive point and window
// zero, send window 10, initial send sequence 0, both stages empty.
module tcp_segment_accept_and_state_core (
   input  logic                                clock,
   input  logic                                reset,
   tcpsa_req_if.sink                           req_chan,
   tcpsa_rsp_if.source                         rsp_chan,
   input  logic                                csr_write_enable,
   input  logic [tcpsa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tcpsa_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import tcpsa_pkg::*;

   logic [SEQ_W-1:0]   initial_send_seq_ff;
   logic [WIN_W-1:0]   send_window_ff;

   logic               s1_valid_ff;
   logic [SEQ_W-1:0]   s1_seq_ff;
   logic [WIN_W-1:0]   s1_win_ff;
   logic [LEN_W-1:0]   s1_plen_ff;
   logic               s1_syn_ff;
   logic               s1_ackf_ff;
   logic               s1_fin_ff;

   phase_type          phase_ff, phase_in;
   logic [SEQ_W-1:0]   recv_next_ff, recv_next_in;
   logic [WIN_W-1:0]   recv_window_ff, recv_window_in;

   logic               rsp_valid_ff;
   logic               accepted_ff, accepted_in;
   action_type         action_ff, action_in;
   phase_type          conn_state_ff;
   logic [SEQ_W-1:0]   reply_seq_ff, reply_seq_in;
   logic [SEQ_W-1:0]   reply_ack_ff, reply_ack_in;
   logic [WIN_W-1:0]   reply_window_ff, reply_window_in;

   logic               out_free;
   logic               advance;
   logic [LEN_W:0]     seg_len;
   logic [SEQ_W-1:0]   seg_len_x;
   logic [SEQ_W-1:0]   win_lo;
   logic [SEQ_W-1:0]   win_hi;
   logic [SEQ_W-1:0]   last_seq;
   logic               first_in;
   logic               last_in;
   logic               ok;

   assign out_free      = !rsp_valid_ff || rsp_chan.ready;
   assign advance       = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         initial_send_seq_ff <= '0;
         send_window_ff      <= SEND_WINDOW_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_INITIAL_SEND_SEQ: initial_send_seq_ff <= csr_write_data[SEQ_W-1:0];
            CSR_SEND_WINDOW:      send_window_ff      <= csr_write_data[WIN_W-1:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         s1_seq_ff  <= req_chan.seg_seq;
         s1_win_ff  <= req_chan.seg_window;
         s1_plen_ff <= req_chan.payload_len;
         s1_syn_ff  <= req_chan.flag_syn;
         s1_ackf_ff <= req_chan.flag_ack;
         s1_fin_ff  <= req_chan.flag_fin;
      end
   end

   // window acceptance
   always_comb begin
      seg_len   = {1'b0, s1_plen_ff} + {{LEN_W{1'b0}}, s1_syn_ff}
                  + {{LEN_W{1'b0}}, s1_fin_ff};
      seg_len_x = {{(SEQ_W-LEN_W-1){1'b0}}, seg_len};
      win_lo    = recv_next_ff - {{(SEQ_W-1){1'b0}}, 1'b1};
      win_hi    = recv_next_ff + {{(SEQ_W-WIN_W){1'b0}}, recv_window_ff};
      last_seq  = s1_seq_ff + seg_len_x - {{(SEQ_W-1){1'b0}}, 1'b1};
      first_in  = serial_lt(win_lo, s1_seq_ff) && serial_lt(s1_seq_ff, win_hi);
      last_in   = serial_lt(win_lo, last_seq) && serial_lt(last_seq, win_hi);
      if (seg_len == '0) begin
         if (recv_window_ff == '0) begin
            ok = (s1_seq_ff == recv_next_ff);
         end else begin
            ok = first_in;
         end
      end else if (recv_window_ff == '0) begin
         ok = 1'b0;
      end else begin
         ok = first_in || last_in;
      end
   end

   // next state and result
   always_comb begin
      phase_in        = phase_ff;
      recv_next_in    = recv_next_ff;
      recv_window_in  = recv_window_ff;
      accepted_in     = 1'b0;
      action_in       = ACT_NONE;
      reply_seq_in    = '0;
      reply_ack_in    = '0;
      reply_window_in = '0;
      if (phase_ff == PH_LISTEN) begin
         recv_next_in    = s1_seq_ff + {{(SEQ_W-1){1'b0}}, 1'b1};
         recv_window_in  = s1_win_ff;
         phase_in        = PH_SYNRCVD;
         accepted_in     = 1'b1;
         action_in       = ACT_SYNACK;
         reply_seq_in    = initial_send_seq_ff;
         reply_ack_in    = s1_seq_ff + {{(SEQ_W-1){1'b0}}, 1'b1};
         reply_window_in = send_window_ff;
      end else if (ok) begin
         accepted_in = 1'b1;
         if (!s1_ackf_ff) begin
            if (s1_syn_ff) begin
               recv_next_in = recv_next_ff + {{(SEQ_W-1){1'b0}}, 1'b1};
            end
         end else begin
            recv_next_in = s1_seq_ff + seg_len_x;
            case (phase_ff)
               PH_SYNRCVD, PH_ESTAB: begin
                  action_in = ACT_FIN;
                  phase_in  = PH_FINWAIT1;
               end
               PH_FINWAIT1: begin
                  if (s1_fin_ff) begin
                     action_in = ACT_RST;
                     phase_in  = PH_FINWAIT2;
                  end
               end
               PH_FINWAIT2: begin
                  phase_in = PH_CLOSING;
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_LISTEN;
         recv_next_ff   <= '0;
         recv_window_ff <= '0;
      end else if (advance) begin
         phase_ff       <= phase_in;
         recv_next_ff   <= recv_next_in;
         recv_window_ff <= recv_window_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         accepted_ff     <= accepted_in;
         action_ff       <= action_in;
         conn_state_ff   <= phase_in;
         reply_seq_ff    <= reply_seq_in;
         reply_ack_ff    <= reply_ack_in;
         reply_window_ff <= reply_window_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.accepted     = accepted_ff;
   assign rsp_chan.action       = action_ff;
   assign rsp_chan.conn_state   = conn_state_ff;
   assign rsp_chan.reply_seq    = reply_seq_ff;
   assign rsp_chan.reply_ack    = reply_ack_ff;
   assign rsp_chan.reply_window = reply_window_ff;

`ifndef NO_ASSERTIONS
   a_listen_opens: assert property (@(posedge clock) disable iff (reset)
      (advance && phase_ff == PH_LISTEN) |=> (phase_ff == PH_SYNRCVD))
      else $error("listen did not open the connection");

   a_no_return_listen: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_LISTEN) |=> (phase_ff != PH_LISTEN))
      else $error("phase went back to listen");

   a_synack_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && action_ff == ACT_SYNACK) |->
         (accepted_ff && conn_state_ff == PH_SYNRCVD))
      else $error("SYN-ACK item with wrong acceptance or state");

   a_reply_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && action_ff != ACT_SYNACK) |->
         (reply_seq_ff == '0 && reply_ack_ff == '0 && reply_window_ff == '0))
      else $error("reply fields set without SYN-ACK");

   a_fin_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && action_ff == ACT_FIN) |-> (conn_state_ff == PH_FINWAIT1))
      else $error("FIN item outside fin-wait-1");
`endif

endmodule

/* tb/sv/tcp_segment_accept_and_state_core_tb.sv */
// ----------------------------------------------------------------------------
// tcp_segment_accept_and_state_core_tb
// Drives received segment headers into the core and checks every result item
// against an in-bench model of the connection: open from listen, serial window
// acceptance, phase walk to closing, and the SYN-ACK reply fields.
// ----------------------------------------------------------------------------
module tcp_segment_accept_and_state_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tcpsa_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int MAX_REPORTS    = 10;

   typedef struct {
      logic [31:0] seq;
      logic [31:0] ack;
      logic [15:0] wnd;
      logic [15:0] plen;
      logic        syn;
      logic        ack_flag;
      logic        fin;
   } segment_type;

   typedef struct {
      logic        accepted;
      action_type  action;
      phase_type   conn_state;
      logic [31:0] reply_seq;
      logic [31:0] reply_ack;
      logic [15:0] reply_window;
   } verdict_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   tcpsa_req_if req_if ();
   tcpsa_rsp_if rsp_if ();

   tcp_segment_accept_and_state_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // connection model
   phase_type   conn_phase;
   logic [31:0] rcv_nxt;
   logic [15:0] rcv_wnd;
   logic [31:0] snd_una;
   logic [31:0] snd_nxt;
   logic [31:0] cfg_iss;
   logic [15:0] cfg_snd_wnd;

   verdict_type verdict_q[$];
   int       mismatches = 0;
   int       results_seen = 0;
   bit       idling = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic precedes(logic [31:0] a, logic [31:0] b);
      logic [31:0] gap;
      gap = a - b;
      return gap > HALF_RANGE;
   endfunction

   function automatic logic in_window(logic [31:0] lo, logic [31:0] x, logic [31:0] hi);
      return precedes(lo, x) && precedes(x, hi);
   endfunction

   function automatic verdict_type step_connection(segment_type s);
      verdict_type v;
      logic [16:0] len;
      logic [31:0] lo, hi, last;
      logic        ok;
      v.accepted     = 1'b0;
      v.action       = ACT_NONE;
      v.reply_seq    = '0;
      v.reply_ack    = '0;
      v.reply_window = '0;
      if (conn_phase == PH_LISTEN) begin
         rcv_nxt        = s.seq + 32'd1;
         rcv_wnd        = s.wnd;
         snd_una        = '0;
         snd_nxt        = cfg_iss + 32'd1;
         conn_phase     = PH_SYNRCVD;
         v.accepted     = 1'b1;
         v.action       = ACT_SYNACK;
         v.reply_seq    = cfg_iss;
         v.reply_ack    = s.seq + 32'd1;
         v.reply_window = cfg_snd_wnd;
      end else begin
         len  = 17'(s.plen) + 17'(s.syn) + 17'(s.fin);
         lo   = rcv_nxt - 32'd1;
         hi   = rcv_nxt + 32'(rcv_wnd);
         last = s.seq + 32'(len) - 32'd1;
         if (len == 0)
            ok = (rcv_wnd == 0) ? (s.seq == rcv_nxt) : in_window(lo, s.seq, hi);
         else if (rcv_wnd == 0)
            ok = 1'b0;
         else
            ok = in_window(lo, s.seq, hi) || in_window(lo, last, hi);
         if (ok) begin
            v.accepted = 1'b1;
            if (!s.ack_flag) begin
               if (s.syn)
                  rcv_nxt = rcv_nxt + 32'd1;
            end else begin
               rcv_nxt = s.seq + 32'(len);
               case (conn_phase)
                  PH_SYNRCVD, PH_ESTAB: begin
                     snd_una    = s.ack;
                     v.action   = ACT_FIN;
                     conn_phase = PH_FINWAIT1;
                  end
                  PH_FINWAIT1: begin
                     if (s.fin) begin
                        v.action   = ACT_RST;
                        conn_phase = PH_FINWAIT2;
                     end
                  end
                  PH_FINWAIT2: conn_phase = PH_CLOSING;
                  default: ;
               endcase
            end
         end
      end
      v.conn_state = conn_phase;
      return v;
   endfunction

   function automatic segment_type shape(logic [31:0] seq, logic [15:0] plen,
                                         logic syn, logic ack_flag, logic fin);
      segment_type s;
      s.seq      = seq;
      s.ack      = $urandom;
      s.wnd      = 16'($urandom);
      s.plen     = plen;
      s.syn      = syn;
      s.ack_flag = ack_flag;
      s.fin      = fin;
      return s;
   endfunction

   function automatic segment_type random_segment();
      segment_type s;
      logic [16:0] len;
      logic [31:0] lo, hi, off;
      s = shape($urandom, 16'd0, $urandom_range(0, 3) == 0, $urandom_range(0, 3) != 0,
                $urandom_range(0, 4) == 0);
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4, 5, 6: s.plen = 16'd0;
         7, 8, 9, 10, 11, 12, 13, 14: s.plen = 16'($urandom_range(1, 16));
         15, 16, 17, 18: s.plen = 16'($urandom_range(17, 1500));
         default: s.plen = 16'($urandom_range(65000, 65535));
      endcase
      len = 17'(s.plen) + 17'(s.syn) + 17'(s.fin);
      lo  = rcv_nxt - 32'd1;
      hi  = rcv_nxt + 32'(rcv_wnd);
      off = 32'($urandom_range(0, 2));
      case ($urandom_range(0, 11))
         0, 1: ;
         2: s.seq = lo + off;
         3: s.seq = hi - 32'd1 + off;
         4: s.seq = lo + off - 32'(len) + 32'd1;
         5: s.seq = hi + off - 32'(len);
         6: s.seq = lo + HALF_RANGE - 32'd1 + off;
         7: s.seq = hi - HALF_RANGE - 32'd1 + off;
         default: s.seq = rcv_nxt + 32'($urandom_range(0, rcv_wnd));
      endcase
      return s;
   endfunction

   function automatic string describe(verdict_type v);
      return $sformatf("acc=%0b act=%0d state=%0d rseq=%h rack=%h rwin=%h",
                       v.accepted, v.action, v.conn_state, v.reply_seq, v.reply_ack,
                       v.reply_window);
   endfunction

   task automatic send_segment(segment_type s);
      if (idling && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.seg_seq     <= s.seq;
      req_if.seg_ack     <= s.ack;
      req_if.seg_window  <= s.wnd;
      req_if.payload_len <= s.plen;
      req_if.flag_syn    <= s.syn;
      req_if.flag_ack    <= s.ack_flag;
      req_if.flag_fin    <= s.fin;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      verdict_q.push_back(step_connection(s));
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
   endtask

   task automatic program_reply(logic [31:0] iss, logic [15:0] wnd);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_INITIAL_SEND_SEQ;
      csr_write_data   <= iss;
      @(posedge clock);
      cfg_iss = iss;
      csr_index      <= CSR_SEND_WINDOW;
      csr_write_data <= {16'($urandom), wnd};
      @(posedge clock);
      cfg_snd_wnd = wnd;
      csr_write_enable <= 1'b0;
   endtask

   task automatic test_open_connection();
      segment_type s;
      if ($urandom_range(0, 1) == 1)
         program_reply(32'hFFFF_FFFF, 16'hFFFF);
      case ($urandom_range(0, 2))
         0: s = shape(32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1);
         1: s = shape(32'h0000_0000, 16'hFFFF, 1'b1, 1'b1, 1'b1);
         default: s = shape($urandom, 16'hFFFF, 1'b1, 1'b1, 1'b1);
      endcase
      s.ack = 32'hFFFF_FFFF;
      case ($urandom_range(0, 7))
         0: s.wnd = 16'd0;
         1: s.wnd = 16'd1;
         2: s.wnd = 16'hFFFF;
         default: s.wnd = 16'($urandom_range(2, 4000));
      endcase
      send_segment(s);
   endtask

   task automatic test_window_edges();
      logic [31:0] lo, hi;
      lo = rcv_nxt - 32'd1;
      hi = rcv_nxt + 32'(rcv_wnd);
      send_segment(shape(lo, 16'd0, 1'b0, 1'b0, 1'b0));
      send_segment(shape(rcv_nxt, 16'd0, 1'b0, 1'b0, 1'b0));
      send_segment(shape(hi - 32'd1, 16'd0, 1'b0, 1'b0, 1'b0));
      send_segment(shape(hi, 16'd0, 1'b0, 1'b0, 1'b0));
      send_segment(shape(rcv_nxt, 16'd1, 1'b0, 1'b0, 1'b0));
      send_segment(shape(lo - 32'd3, 16'd5, 1'b0, 1'b0, 1'b0));
      send_segment(shape(lo - 32'd4, 16'd5, 1'b0, 1'b0, 1'b0));
      send_segment(shape(hi - 32'd1, 16'd3, 1'b0, 1'b0, 1'b0));
      send_segment(shape(lo + HALF_RANGE, 16'd0, 1'b0, 1'b0, 1'b0));
      send_segment(shape(hi - HALF_RANGE, 16'd0, 1'b0, 1'b0, 1'b0));
   endtask

   task automatic test_phase_walk();
      send_segment(shape(rcv_nxt, 16'd3, 1'b1, 1'b0, 1'b0));
      send_segment(shape(rcv_nxt, 16'd5, 1'b0, 1'b1, 1'b0));
      send_segment(shape(rcv_nxt, 16'd0, 1'b0, 1'b1, 1'b0));
      send_segment(shape(rcv_nxt, 16'd0, 1'b0, 1'b1, 1'b1));
      send_segment(shape(rcv_nxt + 32'(rcv_wnd), 16'd0, 1'b0, 1'b1, 1'b0));
      send_segment(shape(rcv_nxt, 16'hFFFF, 1'b1, 1'b1, 1'b1));
      send_segment(shape(rcv_nxt, 16'd0, 1'b0, 1'b1, 1'b0));
      send_segment(shape(rcv_nxt, 16'd2, 1'b0, 1'b1, 1'b1));
   endtask

   task automatic test_random_segments(int count);
      repeat (count) send_segment(random_segment());
   endtask

   initial begin
      int stall_left;
      rsp_if.ready = 1'b0;
      stall_left   = 0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (idling && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      verdict_type got, want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         got.accepted     = rsp_if.accepted;
         got.action       = rsp_if.action;
         got.conn_state   = rsp_if.conn_state;
         got.reply_seq    = rsp_if.reply_seq;
         got.reply_ack    = rsp_if.reply_ack;
         got.reply_window = rsp_if.reply_window;
         if (verdict_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("result %0d with no item outstanding: %s", results_seen,
                        describe(got));
         end else begin
            want = verdict_q.pop_front();
            if (got.accepted !== want.accepted || got.action !== want.action ||
                got.conn_state !== want.conn_state || got.reply_seq !== want.reply_seq ||
                got.reply_ack !== want.reply_ack ||
                got.reply_window !== want.reply_window) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("result %0d mismatch: expected %s, got %s", results_seen,
                           describe(want), describe(got));
            end
         end
         results_seen++;
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
             (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("tcp_segment_accept_and_state_core_tb: FAIL");
      $finish;
   end

   initial begin
      reset              = 1'b1;
      csr_write_enable   = 1'b0;
      csr_index          = CSR_INITIAL_SEND_SEQ;
      csr_write_data     = '0;
      req_if.valid       = 1'b0;
      req_if.seg_seq     = '0;
      req_if.seg_ack     = '0;
      req_if.seg_window  = '0;
      req_if.payload_len = '0;
      req_if.flag_syn    = 1'b0;
      req_if.flag_ack    = 1'b0;
      req_if.flag_fin    = 1'b0;
      conn_phase  = PH_LISTEN;
      rcv_nxt     = '0;
      rcv_wnd     = '0;
      snd_una     = '0;
      snd_nxt     = '0;
      cfg_iss     = '0;
      cfg_snd_wnd = SEND_WINDOW_RESET;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      idling = 1'b1;
      test_open_connection();
      test_window_edges();
      test_phase_walk();

      settle();
      program_reply(32'h0000_0000, 16'h0000);
      test_random_segments(400);

      settle();
      idling = 1'b0;
      program_reply($urandom, 16'($urandom));
      test_random_segments(300);

      settle();
      idling = 1'b1;
      program_reply(32'hFFFF_FFFF, 16'hFFFF);
      test_random_segments(400);

      idling = 1'b0;
      test_random_segments(150);

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("tcp_segment_accept_and_state_core_tb: PASS");
      else
         $display("tcp_segment_accept_and_state_core_tb: FAIL");
      $finish;
   end

endmodule

/* files.f */
sv/tcpsa_pkg.sv
sv/tcpsa_req_if.sv
sv/tcpsa_rsp_if.sv
sv/tcp_segment_accept_and_state_core.sv
tb/sv/tcp_segment_accept_and_state_core_tb.sv
